// ===== sv/hfmc_pkg.sv =====
// Package: shared widths, codes, types and helpers for the hysteresis fan mode controller.
`timescale 1ns / 1ps

package hfmc_pkg;

  // Field widths
  localparam int TEMP_W  = 12;
  localparam int BAND_W  = 9;
  localparam int DUTY_W  = 10;
  localparam int MODE_W  = 2;
  localparam int LIM_W   = TEMP_W + 1;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 12;

  // Sensor counts actually considered per kind (four fields of each kind exist)
  localparam int LOCAL_TEMPS    = 4;
  localparam int SEGMENT_TEMPS  = 4;
  localparam int FIELDS_PER_KIND = 4;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_BASE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WARM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOT  = 2'd2;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_WARM_THR  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_HOT_THR   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_HYST_BAND = 3'd2;
  localparam logic [CFG_IW-1:0] REG_DUTY_BASE = 3'd3;
  localparam logic [CFG_IW-1:0] REG_DUTY_WARM = 3'd4;
  localparam logic [CFG_IW-1:0] REG_DUTY_HOT  = 3'd5;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [LIM_W-1:0]  lim_t;
  typedef logic [BAND_W-1:0]        band_t;
  typedef logic [DUTY_W-1:0]        duty_t;
  typedef logic [MODE_W-1:0]        mode_t;

  // Reset values of the registers
  localparam temp_t RST_WARM_THR  = 12'sd400;
  localparam temp_t RST_HOT_THR   = 12'sd500;
  localparam band_t RST_HYST_BAND = 9'd30;
  localparam duty_t RST_DUTY_BASE = 10'd300;
  localparam duty_t RST_DUTY_WARM = 10'd700;
  localparam duty_t RST_DUTY_HOT  = 10'd1000;

  // Coldest code; stands in for fields that are not considered
  localparam temp_t TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

  typedef struct packed {
    temp_t warm_threshold;
    temp_t hot_threshold;
    band_t hysteresis_band;
    duty_t duty_base;
    duty_t duty_warm;
    duty_t duty_hot;
  } cfg_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  function automatic temp_t max2(input temp_t a, input temp_t b);
    max2 = (b > a) ? b : a;
  endfunction

endpackage

// ===== sv/hfmc_front.sv =====
// Front end: accepts sample beats, finds the hottest temperature, pushes it to the queue.
`timescale 1ns / 1ps

module hfmc_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  hfmc_pkg::temp_t   in_local_temp_0,
  input  hfmc_pkg::temp_t   in_local_temp_1,
  input  hfmc_pkg::temp_t   in_local_temp_2,
  input  hfmc_pkg::temp_t   in_local_temp_3,
  input  hfmc_pkg::temp_t   in_segment_temp_0,
  input  hfmc_pkg::temp_t   in_segment_temp_1,
  input  hfmc_pkg::temp_t   in_segment_temp_2,
  input  hfmc_pkg::temp_t   in_segment_temp_3,
  input  hfmc_pkg::q_status_t q_status,
  output logic              push,
  output hfmc_pkg::temp_t   push_data
);
  import hfmc_pkg::*;

  temp_t loc_raw [FIELDS_PER_KIND];
  temp_t seg_raw [FIELDS_PER_KIND];
  temp_t loc_m   [FIELDS_PER_KIND];
  temp_t seg_m   [FIELDS_PER_KIND];
  temp_t loc_a, loc_b, seg_a, seg_b, loc_max, seg_max;

  assign loc_raw[0] = in_local_temp_0;
  assign loc_raw[1] = in_local_temp_1;
  assign loc_raw[2] = in_local_temp_2;
  assign loc_raw[3] = in_local_temp_3;
  assign seg_raw[0] = in_segment_temp_0;
  assign seg_raw[1] = in_segment_temp_1;
  assign seg_raw[2] = in_segment_temp_2;
  assign seg_raw[3] = in_segment_temp_3;

  // Fields past the configured count drop to the coldest code
  always_comb begin
    for (int i = 0; i < FIELDS_PER_KIND; i++) begin
      loc_m[i] = (i < LOCAL_TEMPS)   ? loc_raw[i] : TEMP_MIN;
      seg_m[i] = (i < SEGMENT_TEMPS) ? seg_raw[i] : TEMP_MIN;
    end
  end

  // Three-level max tree
  assign loc_a     = max2(loc_m[0], loc_m[1]);
  assign loc_b     = max2(loc_m[2], loc_m[3]);
  assign seg_a     = max2(seg_m[0], seg_m[1]);
  assign seg_b     = max2(seg_m[2], seg_m[3]);
  assign loc_max   = max2(loc_a, loc_b);
  assign seg_max   = max2(seg_a, seg_b);
  assign push_data = max2(loc_max, seg_max);

  // Hold off only while the queue is full
  assign in_stall = q_status.full;
  assign push     = in_valid & ~q_status.full;

endmodule

// ===== sv/hfmc_queue.sv =====
// Short queue carrying hottest temperatures from front to back.
`timescale 1ns / 1ps

module hfmc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hfmc_pkg::temp_t     push_data,
  input  logic                pop,
  output hfmc_pkg::temp_t     head_data,
  output hfmc_pkg::q_status_t q_status
);
  import hfmc_pkg::*;

  temp_t            q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_status.full      = (count_r == Q_CW'(Q_DEPTH));
  assign q_status.not_empty = (count_r != '0);
  assign do_push = push & ~q_status.full;
  assign do_pop  = pop & q_status.not_empty;
  assign head_data = q_mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/hfmc_back.sv =====
// Back end: mode state machine with hysteresis, duty lookup and output register.
`timescale 1ns / 1ps

module hfmc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hfmc_pkg::cfg_t      cfg,
  input  hfmc_pkg::q_status_t q_status,
  input  hfmc_pkg::temp_t     head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output hfmc_pkg::mode_t     out_applied_mode,
  output hfmc_pkg::duty_t     out_fan_duty,
  output hfmc_pkg::temp_t     out_hottest_temp
);
  import hfmc_pkg::*;

  mode_t mode_r, mode_nxt;
  logic  out_valid_r, out_valid_nxt;
  mode_t out_mode_r;
  duty_t out_duty_r;
  temp_t out_hot_r;
  duty_t duty;
  lim_t  hot_ext, warm_lo, hot_lo;

  // Pop whenever the output register is free or being drained
  assign pop = q_status.not_empty & (~out_valid_r | ~out_stall);

  // Step-down limits at full precision
  assign hot_ext = $signed({head_data[TEMP_W-1], head_data});
  assign warm_lo = $signed({cfg.warm_threshold[TEMP_W-1], cfg.warm_threshold})
                 - $signed({{(LIM_W-BAND_W){1'b0}}, cfg.hysteresis_band});
  assign hot_lo  = $signed({cfg.hot_threshold[TEMP_W-1], cfg.hot_threshold})
                 - $signed({{(LIM_W-BAND_W){1'b0}}, cfg.hysteresis_band});

  // Mode transition and duty of the mode in force
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      MODE_BASE: begin
        duty = cfg.duty_base;
        if (head_data > cfg.warm_threshold) begin
          mode_nxt = MODE_WARM;
        end
      end
      MODE_WARM: begin
        duty = cfg.duty_warm;
        if (head_data > cfg.hot_threshold) begin
          mode_nxt = MODE_HOT;
        end else if (hot_ext < warm_lo) begin
          mode_nxt = MODE_BASE;
        end
      end
      default: begin
        // hot, and the unused code behaves as hot
        duty = cfg.duty_hot;
        if (hot_ext < hot_lo) begin
          mode_nxt = MODE_WARM;
        end
      end
    endcase
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_BASE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        mode_r <= mode_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_mode_r <= mode_r;
      out_duty_r <= duty;
      out_hot_r  <= head_data;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_applied_mode = out_mode_r;
  assign out_fan_duty     = out_duty_r;
  assign out_hottest_temp = out_hot_r;

endmodule

// ===== sv/hysteresis_fan_mode_control_unit.sv =====
// Top level: configuration registers, front end, queue and back end of the fan mode controller.
// Throughput: one sample beat per cycle, sustained while out_stall stays low (a full queue raises in_stall).
// Path: each input beat is written into the queue, then its result is captured in the output register.
// The two-entry queue lets the input keep accepting while a result waits on out_stall.
// Reset (rst_n low, synchronous): mode returns to base, queue empties, no result is valid,
// and all configuration registers take their default values.
`timescale 1ns / 1ps

module hysteresis_fan_mode_control_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [hfmc_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [hfmc_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  hfmc_pkg::temp_t              in_local_temp_0,
  input  hfmc_pkg::temp_t              in_local_temp_1,
  input  hfmc_pkg::temp_t              in_local_temp_2,
  input  hfmc_pkg::temp_t              in_local_temp_3,
  input  hfmc_pkg::temp_t              in_segment_temp_0,
  input  hfmc_pkg::temp_t              in_segment_temp_1,
  input  hfmc_pkg::temp_t              in_segment_temp_2,
  input  hfmc_pkg::temp_t              in_segment_temp_3,
  output logic                         out_valid,
  input  logic                         out_stall,
  output hfmc_pkg::mode_t              out_applied_mode,
  output hfmc_pkg::duty_t              out_fan_duty,
  output hfmc_pkg::temp_t              out_hottest_temp
);
  import hfmc_pkg::*;

  cfg_t      cfg_r;
  q_status_t q_status;
  logic      push, pop;
  temp_t     push_data, head_data;

  // Configuration register file; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warm_threshold  <= RST_WARM_THR;
      cfg_r.hot_threshold   <= RST_HOT_THR;
      cfg_r.hysteresis_band <= RST_HYST_BAND;
      cfg_r.duty_base       <= RST_DUTY_BASE;
      cfg_r.duty_warm       <= RST_DUTY_WARM;
      cfg_r.duty_hot        <= RST_DUTY_HOT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WARM_THR:  cfg_r.warm_threshold  <= cfg_wdata[TEMP_W-1:0];
        REG_HOT_THR:   cfg_r.hot_threshold   <= cfg_wdata[TEMP_W-1:0];
        REG_HYST_BAND: cfg_r.hysteresis_band <= cfg_wdata[BAND_W-1:0];
        REG_DUTY_BASE: cfg_r.duty_base       <= cfg_wdata[DUTY_W-1:0];
        REG_DUTY_WARM: cfg_r.duty_warm       <= cfg_wdata[DUTY_W-1:0];
        REG_DUTY_HOT:  cfg_r.duty_hot        <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  hfmc_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_local_temp_0   (in_local_temp_0),
    .in_local_temp_1   (in_local_temp_1),
    .in_local_temp_2   (in_local_temp_2),
    .in_local_temp_3   (in_local_temp_3),
    .in_segment_temp_0 (in_segment_temp_0),
    .in_segment_temp_1 (in_segment_temp_1),
    .in_segment_temp_2 (in_segment_temp_2),
    .in_segment_temp_3 (in_segment_temp_3),
    .q_status          (q_status),
    .push              (push),
    .push_data         (push_data)
  );

  hfmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .q_status  (q_status)
  );

  hfmc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_status         (q_status),
    .head_data        (head_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_applied_mode (out_applied_mode),
    .out_fan_duty     (out_fan_duty),
    .out_hottest_temp (out_hottest_temp)
  );

endmodule

// ===== sv/hfmc_checker.sv =====
// Port-level checker for the fan mode controller, bound to the top level.
`timescale 1ns / 1ps

module hfmc_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input hfmc_pkg::mode_t out_applied_mode,
  input hfmc_pkg::duty_t out_fan_duty,
  input hfmc_pkg::temp_t out_hottest_temp
);
  import hfmc_pkg::*;

  mode_t last_mode_r;
  logic  seen_r;

  // Mode of the last delivered result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      last_mode_r <= MODE_BASE;
    end else if (out_valid && !out_stall) begin
      seen_r      <= 1'b1;
      last_mode_r <= out_applied_mode;
    end
  end

  // No result is shown right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Only the three defined modes reach the output
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_applied_mode == MODE_BASE) || (out_applied_mode == MODE_WARM) ||
                   (out_applied_mode == MODE_HOT)))
    else $error("illegal applied mode");

  // The mode moves at most one level between consecutive results
  a_mode_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && seen_r) |->
      !((last_mode_r == MODE_BASE) && (out_applied_mode == MODE_HOT)) &&
      !((last_mode_r == MODE_HOT) && (out_applied_mode == MODE_BASE)))
    else $error("mode skipped a level");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_applied_mode) && $stable(out_fan_duty) &&
       $stable(out_hottest_temp)))
    else $error("stalled result changed");

endmodule

bind hysteresis_fan_mode_control_unit hfmc_checker u_hfmc_checker (.*);

// ===== verif/fan_mode_checker.sv =====
// Checker: predicts fan mode results from sample beats and compares them with result beats.
`timescale 1ns / 1ps

module fan_mode_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [hfmc_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [hfmc_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  hfmc_pkg::temp_t              in_local_temp_0,
  input  hfmc_pkg::temp_t              in_local_temp_1,
  input  hfmc_pkg::temp_t              in_local_temp_2,
  input  hfmc_pkg::temp_t              in_local_temp_3,
  input  hfmc_pkg::temp_t              in_segment_temp_0,
  input  hfmc_pkg::temp_t              in_segment_temp_1,
  input  hfmc_pkg::temp_t              in_segment_temp_2,
  input  hfmc_pkg::temp_t              in_segment_temp_3,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  hfmc_pkg::mode_t              out_applied_mode,
  input  hfmc_pkg::duty_t              out_fan_duty,
  input  hfmc_pkg::temp_t              out_hottest_temp,
  output int                           mismatches,
  output int                           outstanding
);
  import hfmc_pkg::*;

  typedef struct packed {
    mode_t mode;
    duty_t duty;
    temp_t hottest;
  } fan_result_t;

  // predicted results, oldest first
  fan_result_t fan_results_q[$];

  // shadow of the register file and the mode register
  temp_t warm_thr;
  temp_t hot_thr;
  band_t band;
  duty_t duty_base;
  duty_t duty_warm;
  duty_t duty_hot;
  mode_t cooling_mode;
  int    err_count = 0;

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    temp_t       temps [8];
    fan_result_t want;
    int          peak;
    if (!rst_n) begin
      warm_thr     = RST_WARM_THR;
      hot_thr      = RST_HOT_THR;
      band         = RST_HYST_BAND;
      duty_base    = RST_DUTY_BASE;
      duty_warm    = RST_DUTY_WARM;
      duty_hot     = RST_DUTY_HOT;
      cooling_mode = MODE_BASE;
      fan_results_q.delete();
    end else begin
      // result beat: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (fan_results_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got mode %0d duty %0d hottest %0d",
                   $time, out_applied_mode, out_fan_duty, out_hottest_temp);
          err_count++;
        end else begin
          want = fan_results_q.pop_front();
          check_field("applied_mode", want.mode, out_applied_mode);
          check_field("fan_duty", want.duty, out_fan_duty);
          check_field("hottest_temp", want.hottest, out_hottest_temp);
        end
      end

      // register write; unknown indexes fall through
      if (cfg_we) begin
        case (cfg_index)
          REG_WARM_THR:  warm_thr  = cfg_wdata[TEMP_W-1:0];
          REG_HOT_THR:   hot_thr   = cfg_wdata[TEMP_W-1:0];
          REG_HYST_BAND: band      = cfg_wdata[BAND_W-1:0];
          REG_DUTY_BASE: duty_base = cfg_wdata[DUTY_W-1:0];
          REG_DUTY_WARM: duty_warm = cfg_wdata[DUTY_W-1:0];
          REG_DUTY_HOT:  duty_hot  = cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end

      // sample beat: hottest reading, duty of the current mode, then mode update
      if (in_valid && !in_stall) begin
        temps[0] = in_local_temp_0;
        temps[1] = in_local_temp_1;
        temps[2] = in_local_temp_2;
        temps[3] = in_local_temp_3;
        temps[4] = in_segment_temp_0;
        temps[5] = in_segment_temp_1;
        temps[6] = in_segment_temp_2;
        temps[7] = in_segment_temp_3;
        peak = -10000;
        for (int i = 0; i < LOCAL_TEMPS && i < FIELDS_PER_KIND; i++)
          if (int'(temps[i]) > peak) peak = int'(temps[i]);
        for (int i = 0; i < SEGMENT_TEMPS && i < FIELDS_PER_KIND; i++)
          if (int'(temps[FIELDS_PER_KIND + i]) > peak) peak = int'(temps[FIELDS_PER_KIND + i]);

        want.mode    = cooling_mode;
        want.hottest = peak[TEMP_W-1:0];
        case (cooling_mode)
          MODE_BASE: begin
            want.duty = duty_base;
            if (peak > int'(warm_thr)) cooling_mode = MODE_WARM;
          end
          MODE_WARM: begin
            want.duty = duty_warm;
            if (peak > int'(hot_thr)) cooling_mode = MODE_HOT;
            else if (peak < int'(warm_thr) - int'(band)) cooling_mode = MODE_BASE;
          end
          // hot, and the unused code that behaves like it
          default: begin
            want.duty = duty_hot;
            if (peak < int'(hot_thr) - int'(band)) cooling_mode = MODE_WARM;
          end
        endcase
        fan_results_q.push_back(want);
      end
    end
    mismatches  <= err_count;
    outstanding <= fan_results_q.size();
  end

endmodule

// ===== verif/hysteresis_fan_mode_control_unit_test.sv =====
// Testbench top: drives samples, register writes and output stalls, and reports the verdict.
`timescale 1ns / 1ps

module hysteresis_fan_mode_control_unit_test;
  import hfmc_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 8;
  // indexes with no register behind them
  localparam logic [CFG_IW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    temp_t loc0;
    temp_t loc1;
    temp_t loc2;
    temp_t loc3;
    temp_t seg0;
    temp_t seg1;
    temp_t seg2;
    temp_t seg3;
  } sample_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  sample_t           drive;
  logic              out_valid;
  logic              out_stall = 1'b0;
  mode_t             out_applied_mode;
  duty_t             out_fan_duty;
  temp_t             out_hottest_temp;
  int                mismatches;
  int                outstanding;

  bit steady;              // no idling on either side while set
  int stall_left = 0;
  int cur_warm;
  int cur_hot;
  int cur_band;
  int beats_sent = 0;
  int settings_used = 1;
  int cycle_count;

  hysteresis_fan_mode_control_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_local_temp_0   (drive.loc0),
    .in_local_temp_1   (drive.loc1),
    .in_local_temp_2   (drive.loc2),
    .in_local_temp_3   (drive.loc3),
    .in_segment_temp_0 (drive.seg0),
    .in_segment_temp_1 (drive.seg1),
    .in_segment_temp_2 (drive.seg2),
    .in_segment_temp_3 (drive.seg3),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_applied_mode  (out_applied_mode),
    .out_fan_duty      (out_fan_duty),
    .out_hottest_temp  (out_hottest_temp)
  );

  fan_mode_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_local_temp_0   (drive.loc0),
    .in_local_temp_1   (drive.loc1),
    .in_local_temp_2   (drive.loc2),
    .in_local_temp_3   (drive.loc3),
    .in_segment_temp_0 (drive.seg0),
    .in_segment_temp_1 (drive.seg1),
    .in_segment_temp_2 (drive.seg2),
    .in_segment_temp_3 (drive.seg3),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_applied_mode  (out_applied_mode),
    .out_fan_duty      (out_fan_duty),
    .out_hottest_temp  (out_hottest_temp),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycle_count, outstanding);
    $display("status: fail");
    $finish;
  end

  // result side: random stall after each accepted beat, plus stray stalls
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      draw = steady ? 0 : $urandom_range(0, 6);
      out_stall  <= (draw > 0);
      stall_left <= (draw > 0) ? draw - 1 : 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= steady ? 1'b0 : ($urandom_range(0, 7) == 0);
    end
  end

  function automatic int clamp12(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  // peak in a random field, the rest at or below it
  function automatic sample_t spread_sample(input int peak);
    temp_t   t [8];
    int      p;
    int      v;
    int      peak_pos;
    sample_t s;
    p = clamp12(peak);
    peak_pos = $urandom_range(0, 7);
    for (int i = 0; i < 8; i++) begin
      v = (i == peak_pos) ? p : clamp12(p - int'($urandom_range(0, 400)));
      t[i] = v[TEMP_W-1:0];
    end
    s = {t[0], t[1], t[2], t[3], t[4], t[5], t[6], t[7]};
    return s;
  endfunction

  // mostly near a threshold or a step-down point, some anywhere, some raw bits
  function automatic sample_t random_sample();
    int      pick;
    int      base;
    sample_t s;
    pick = $urandom_range(0, 9);
    if (pick == 9) begin
      s = {$urandom(), $urandom(), $urandom()};
      return s;
    end
    if (pick <= 5) begin
      case ($urandom_range(0, 3))
        0: base = cur_warm;
        1: base = cur_hot;
        2: base = cur_warm - cur_band;
        default: base = cur_hot - cur_band;
      endcase
      return spread_sample(base + int'($urandom_range(0, 8)) - 4);
    end
    if (pick <= 7) return spread_sample(int'($urandom_range(0, 2050)) - 550);
    return spread_sample(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  task automatic send_beat(input sample_t s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    drive    <= s;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // hold off until every predicted result has come out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[CFG_DW-1:0];
    @(posedge clk);
  endtask

  task automatic set_limits(input int warm, input int hot, input int hyst,
                            input int d_base, input int d_warm, input int d_hot);
    write_reg(REG_WARM_THR, warm);
    write_reg(REG_HOT_THR, hot);
    write_reg(REG_HYST_BAND, hyst);
    write_reg(REG_DUTY_BASE, d_base);
    write_reg(REG_DUTY_WARM, d_warm);
    write_reg(REG_DUTY_HOT, d_hot);
    write_reg(REG_SPARE_LO, $urandom_range(0, 4095));
    write_reg(REG_SPARE_HI, $urandom_range(0, 4095));
    cfg_we   <= 1'b0;
    cur_warm = warm;
    cur_hot  = hot;
    cur_band = hyst & 511;
    settings_used++;
  endtask

  // default registers: field extremes, each field as the hottest, every transition edge
  task automatic run_directed();
    sample_t s;
    send_beat({8{temp_t'(-550)}});
    for (int k = 0; k < 8; k++) begin
      s = {8{temp_t'(-550)}};
      s[(7 - k) * TEMP_W +: TEMP_W] = 12'sd350;
      send_beat(s);
    end
    send_beat(spread_sample(400));    // equal to warm threshold: stays base
    send_beat(spread_sample(401));    // rises to warm
    send_beat(spread_sample(500));    // equal to hot threshold: stays warm
    send_beat(spread_sample(370));    // on the step-down point: stays warm
    send_beat(spread_sample(369));    // falls to base
    send_beat(spread_sample(2047));   // raw top code: warm
    send_beat(spread_sample(501));    // hot
    send_beat(spread_sample(470));    // on the step-down point: stays hot
    send_beat(spread_sample(469));    // back to warm
    send_beat(spread_sample(1500));   // hot
    send_beat(spread_sample(-2048));  // raw bottom code: warm
    send_beat(spread_sample(-2048));  // base
    send_beat(spread_sample(-1));     // all below zero
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      if ($urandom_range(0, 149) == 0) drain();
      send_beat(random_sample());
    end
  endtask

  // stimulus
  initial begin
    int w;
    int h;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    drive     <= '0;
    steady    = 1'b0;
    cur_warm  = RST_WARM_THR;
    cur_hot   = RST_HOT_THR;
    cur_band  = RST_HYST_BAND;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain();

    // extreme settings: range ends, inverted thresholds, raw codes past the range
    set_limits(-550, 1500, 0, 0, 1000, 1023);
    run_random(50);
    drain();
    set_limits(1500, -550, 500, 1000, 0, 512);
    run_random(50);
    drain();
    set_limits(-2048, 2047, 4095, 4095, 4095, 4095);
    run_random(50);
    drain();

    // random settings within range
    for (int p = 0; p < 6; p++) begin
      w = int'($urandom_range(0, 2050)) - 550;
      h = int'($urandom_range(0, 2050)) - 550;
      set_limits(w, h, $urandom_range(0, 500), $urandom_range(0, 1000),
                 $urandom_range(0, 1000), $urandom_range(0, 1000));
      run_random(246);
      drain();
    end

    $display("sent %0d sample beats over %0d register settings with random gaps and stalls",
             beats_sent, settings_used);
    $display("covered strict threshold edges, hysteresis step-downs and raw out-of-range codes");
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
      $display("status: fail");
    end
    $finish;
  end

endmodule
